>>> src/fpm_pkg.sv
package fpm_pkg;

   localparam int VCOUNT_W = 9;
   localparam int COORD_W = 24;
   localparam int FRAC_W = 16;
   localparam int IDX_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int DEF_MAX_VERTICES = 256;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEATHER_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEATHER_SCALE_CAP = 2'd2;

   localparam logic [VCOUNT_W-1:0] RST_VERTEX_COUNT = 9'd4;
   localparam logic [FRAC_W-1:0] RST_FEATHER_LENGTH = 16'd13107;
   localparam logic [FRAC_W-1:0] RST_FEATHER_SCALE_CAP = 16'd13107;

   // pipeline depth split
   localparam int FRONT_ST = 3;
   localparam int SQRT_ST = 12;
   localparam int DIV_ST = 8;
   localparam int TOTAL_ST = FRONT_ST + SQRT_ST + DIV_ST + 2;

   localparam logic [1:0] PH_FAN = 2'd0;
   localparam logic [1:0] PH_RING_A = 2'd1;
   localparam logic [1:0] PH_RING_B = 2'd2;

   typedef struct packed {
      logic [IDX_W-1:0] j;
      logic [VCOUNT_W-1:0] n;
      logic err;
      logic negx;
      logic negz;
      logic [COORD_W-1:0] magx;
      logic [COORD_W-1:0] magz;
   } side_type;

endpackage

>>> src/feathered_polygon_mesh_core.sv
// structure: 25 pipeline stages followed by the output stage
// throughput: one vertex per cycle through the pipeline unless the output stage holds it;
//   the output stage emits up to three results per vertex through the single result port
//   and takes a new vertex only once the last result of the previous one is transferred
// reset: synchronous active high, clears valid bits and restores register defaults
module feathered_polygon_mesh_core
   import fpm_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic clock,
   input  logic reset,
   // vertex input channel
   input  logic req_valid,
   output logic req_stall,
   input  logic [IDX_W-1:0] req_vertex_index,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_z,
   // triangle result channel
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [COORD_W-1:0] rsp_inner_x,
   output logic signed [COORD_W-1:0] rsp_inner_z,
   output logic [VCOUNT_W-1:0] rsp_corner_one,
   output logic [VCOUNT_W-1:0] rsp_corner_two,
   output logic [VCOUNT_W-1:0] rsp_corner_three,
   output logic rsp_last_of_item,
   output logic rsp_index_error,
   // register write channel
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SQ0 = FRONT_ST;
   localparam int DV0 = FRONT_ST + SQRT_ST;
   localparam int MUL = DV0 + DIV_ST;
   localparam int RND = MUL + 1;

   // ---------------- configuration registers ----------------
   logic [VCOUNT_W-1:0] vcount_ff;
   logic [FRAC_W-1:0] flen_ff;
   logic [FRAC_W-1:0] fcap_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= RST_VERTEX_COUNT;
         flen_ff <= RST_FEATHER_LENGTH;
         fcap_ff <= RST_FEATHER_SCALE_CAP;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vcount_ff <= csr_data[VCOUNT_W-1:0];
            CSR_FEATHER_LENGTH: flen_ff <= csr_data;
            CSR_FEATHER_SCALE_CAP: fcap_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp N into 3..MAX_VERTICES
   logic [VCOUNT_W-1:0] n_eff;
   always_comb begin
      if (vcount_ff < VCOUNT_W'(3)) begin
         n_eff = VCOUNT_W'(3);
      end else if (32'(vcount_ff) > 32'(MAX_VERTICES)) begin
         n_eff = VCOUNT_W'(MAX_VERTICES);
      end else begin
         n_eff = vcount_ff;
      end
   end

   // ---------------- pipeline control ----------------
   // every stage moves together; the output stage holds the pipe while it
   // is still handing out the triangles of the previous vertex
   logic adv;
   logic [TOTAL_ST-1:0] vld_ff;
   side_type side_ff [TOTAL_ST];

   assign req_stall = !adv;

   side_type side_in;
   always_comb begin
      side_in.j = req_vertex_index;
      side_in.n = n_eff;
      side_in.err = {1'b0, req_vertex_index} >= n_eff;
      side_in.negx = req_pos_x[COORD_W-1];
      side_in.negz = req_pos_z[COORD_W-1];
      side_in.magx = req_pos_x[COORD_W-1] ? COORD_W'(-req_pos_x) : req_pos_x;
      side_in.magz = req_pos_z[COORD_W-1] ? COORD_W'(-req_pos_z) : req_pos_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[TOTAL_ST-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < TOTAL_ST; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // ---------------- squared length ----------------
   logic [2*COORD_W-1:0] sqx_ff, sqz_ff, rad_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= side_ff[0].magx * side_ff[0].magx;
         sqz_ff <= side_ff[0].magz * side_ff[0].magz;
         rad_ff <= sqx_ff + sqz_ff;
      end
   end

   // ---------------- integer square root, two root bits per stage ----------------
   logic [25:0] sq_rem_ff [SQRT_ST];
   logic [COORD_W-1:0] sq_root_ff [SQRT_ST];
   logic [2*COORD_W-1:0] sq_rad_ff [SQRT_ST];
   logic [25:0] sq_rem_in [SQRT_ST];
   logic [COORD_W-1:0] sq_root_in [SQRT_ST];
   logic [2*COORD_W-1:0] sq_rad_in [SQRT_ST];

   always_comb begin
      logic [27:0] t_rem;
      logic [27:0] trial;
      logic [COORD_W-1:0] t_root;
      logic [2*COORD_W-1:0] t_rad;
      for (int s = 0; s < SQRT_ST; s++) begin
         if (s == 0) begin
            t_rem = '0;
            t_root = '0;
            t_rad = rad_ff;
         end else begin
            t_rem = 28'(sq_rem_ff[s-1]);
            t_root = sq_root_ff[s-1];
            t_rad = sq_rad_ff[s-1];
         end
         for (int k = 0; k < 2; k++) begin
            t_rem = {t_rem[25:0], t_rad[2*COORD_W-1 -: 2]};
            t_rad = {t_rad[2*COORD_W-3:0], 2'b00};
            trial = {2'b00, t_root, 2'b01};
            if (t_rem >= trial) begin
               t_rem = t_rem - trial;
               t_root = {t_root[COORD_W-2:0], 1'b1};
            end else begin
               t_root = {t_root[COORD_W-2:0], 1'b0};
            end
         end
         sq_rem_in[s] = t_rem[25:0];
         sq_root_in[s] = t_root;
         sq_rad_in[s] = t_rad;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < SQRT_ST; s++) begin
            sq_rem_ff[s] <= sq_rem_in[s];
            sq_root_ff[s] <= sq_root_in[s];
            sq_rad_ff[s] <= sq_rad_in[s];
         end
      end
   end

   // ---------------- ratio L/len, two quotient bits per stage ----------------
   // when L >= len the ratio is at least one and the cap wins; a zero length
   // also takes the cap, so both cases travel as a saturate flag
   logic [COORD_W-1:0] len_w;
   assign len_w = sq_root_ff[SQRT_ST-1];

   logic [COORD_W-1:0] dv_r_ff [DIV_ST];
   logic [FRAC_W-1:0] dv_q_ff [DIV_ST];
   logic [COORD_W-1:0] dv_len_ff [DIV_ST];
   logic dv_sat_ff [DIV_ST];
   logic [COORD_W-1:0] dv_r_in [DIV_ST];
   logic [FRAC_W-1:0] dv_q_in [DIV_ST];
   logic [COORD_W-1:0] dv_len_in [DIV_ST];
   logic dv_sat_in [DIV_ST];

   always_comb begin
      logic [COORD_W:0] t_r;
      logic [FRAC_W-1:0] t_q;
      logic [COORD_W-1:0] t_len;
      logic t_sat;
      for (int d = 0; d < DIV_ST; d++) begin
         if (d == 0) begin
            t_len = len_w;
            t_sat = (len_w == '0) || (COORD_W'(flen_ff) >= len_w);
            t_r = t_sat ? '0 : (COORD_W+1)'(flen_ff);
            t_q = '0;
         end else begin
            t_len = dv_len_ff[d-1];
            t_sat = dv_sat_ff[d-1];
            t_r = (COORD_W+1)'(dv_r_ff[d-1]);
            t_q = dv_q_ff[d-1];
         end
         for (int k = 0; k < 2; k++) begin
            t_r = {t_r[COORD_W-1:0], 1'b0};
            if (t_r >= (COORD_W+1)'(t_len)) begin
               t_r = t_r - (COORD_W+1)'(t_len);
               t_q = {t_q[FRAC_W-2:0], 1'b1};
            end else begin
               t_q = {t_q[FRAC_W-2:0], 1'b0};
            end
         end
         dv_r_in[d] = t_r[COORD_W-1:0];
         dv_q_in[d] = t_q;
         dv_len_in[d] = t_len;
         dv_sat_in[d] = t_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int d = 0; d < DIV_ST; d++) begin
            dv_r_ff[d] <= dv_r_in[d];
            dv_q_ff[d] <= dv_q_in[d];
            dv_len_ff[d] <= dv_len_in[d];
            dv_sat_ff[d] <= dv_sat_in[d];
         end
      end
   end

   // ---------------- scale and multiply ----------------
   logic [FRAC_W-1:0] shrink;
   logic [FRAC_W:0] scale;
   logic [COORD_W+FRAC_W:0] px_ff, pz_ff;

   always_comb begin
      if (dv_sat_ff[DIV_ST-1] || dv_q_ff[DIV_ST-1] > fcap_ff) begin
         shrink = fcap_ff;
      end else begin
         shrink = dv_q_ff[DIV_ST-1];
      end
      scale = {1'b1, {FRAC_W{1'b0}}} - (FRAC_W+1)'(shrink);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= side_ff[MUL-1].magx * scale;
         pz_ff <= side_ff[MUL-1].magz * scale;
      end
   end

   // ---------------- round half away from zero, restore sign ----------------
   localparam logic [COORD_W+FRAC_W:0] HALF = (COORD_W+FRAC_W+1)'(1) << (FRAC_W-1);
   logic [COORD_W+FRAC_W:0] rx_sum, rz_sum;
   logic [COORD_W-1:0] mx_r, mz_r;
   logic [COORD_W-1:0] ix_ff, iz_ff;

   always_comb begin
      rx_sum = px_ff + HALF;
      rz_sum = pz_ff + HALF;
      mx_r = rx_sum[FRAC_W +: COORD_W];
      mz_r = rz_sum[FRAC_W +: COORD_W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ix_ff <= side_ff[RND-1].negx ? -mx_r : mx_r;
         iz_ff <= side_ff[RND-1].negz ? -mz_r : mz_r;
      end
   end

   // ---------------- output stage: one triangle per transfer ----------------
   logic ov_ff;
   logic [1:0] ph_ff;
   logic [COORD_W-1:0] ox_ff, oz_ff;
   side_type os_ff;

   logic [VCOUNT_W:0] j_ext, n_ext, nj, nxt;
   logic has_fan;
   logic last_w;
   logic done;

   always_comb begin
      j_ext = (VCOUNT_W+1)'(side_ff[TOTAL_ST-1].j);
      n_ext = (VCOUNT_W+1)'(side_ff[TOTAL_ST-1].n);
      has_fan = (j_ext >= (VCOUNT_W+1)'(1)) && (j_ext + (VCOUNT_W+1)'(2) <= n_ext);
   end

   assign last_w = os_ff.err || (ph_ff == PH_RING_B);
   assign done = ov_ff && !rsp_stall && last_w;
   assign adv = !ov_ff || done;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
         ph_ff <= PH_FAN;
      end else if (adv) begin
         ov_ff <= vld_ff[TOTAL_ST-1];
         ph_ff <= has_fan ? PH_FAN : PH_RING_A;
      end else if (!rsp_stall) begin
         ph_ff <= ph_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         os_ff <= side_ff[TOTAL_ST-1];
         ox_ff <= ix_ff;
         oz_ff <= iz_ff;
      end
   end

   always_comb begin
      logic [VCOUNT_W:0] oj, on;
      oj = (VCOUNT_W+1)'(os_ff.j);
      on = (VCOUNT_W+1)'(os_ff.n);
      nj = on + oj;
      nxt = (oj + (VCOUNT_W+1)'(1) == on) ? '0 : oj + (VCOUNT_W+1)'(1);
      rsp_corner_one = '0;
      rsp_corner_two = '0;
      rsp_corner_three = '0;
      if (!os_ff.err) begin
         case (ph_ff)
            PH_FAN: begin
               rsp_corner_one = on[VCOUNT_W-1:0];
               rsp_corner_two = nj[VCOUNT_W-1:0];
               rsp_corner_three = VCOUNT_W'(nj + (VCOUNT_W+1)'(1));
            end
            PH_RING_A: begin
               rsp_corner_one = oj[VCOUNT_W-1:0];
               rsp_corner_two = nxt[VCOUNT_W-1:0];
               rsp_corner_three = nj[VCOUNT_W-1:0];
            end
            PH_RING_B: begin
               rsp_corner_one = nj[VCOUNT_W-1:0];
               rsp_corner_two = nxt[VCOUNT_W-1:0];
               rsp_corner_three = VCOUNT_W'(on + nxt);
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_inner_x = os_ff.err ? '0 : ox_ff;
   assign rsp_inner_z = os_ff.err ? '0 : oz_ff;
   assign rsp_last_of_item = last_w;
   assign rsp_index_error = os_ff.err;

endmodule

>>> src/fpm_checker.sv
module fpm_checker
   import fpm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic signed [COORD_W-1:0] rsp_inner_x,
   input logic signed [COORD_W-1:0] rsp_inner_z,
   input logic [VCOUNT_W-1:0] rsp_corner_one,
   input logic [VCOUNT_W-1:0] rsp_corner_two,
   input logic [VCOUNT_W-1:0] rsp_corner_three,
   input logic rsp_last_of_item,
   input logic rsp_index_error
);

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_corner_one)
         && $stable(rsp_inner_x) && $stable(rsp_last_of_item))
      else $error("stalled result changed");

   // an error result is a single, last transfer
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_last_of_item)
      else $error("error result not last");

   // error results carry zero payload
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_corner_one == '0 && rsp_corner_two == '0
         && rsp_corner_three == '0 && rsp_inner_x == '0 && rsp_inner_z == '0)
      else $error("error result payload not zero");

   // a non-last transfer is followed by more of the same vertex
   a_same_vertex: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_item |=> rsp_valid
         && $stable(rsp_inner_x) && $stable(rsp_inner_z) && !rsp_index_error)
      else $error("vertex changed within one item");

endmodule

bind feathered_polygon_mesh_core fpm_checker u_fpm_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_inner_x(rsp_inner_x),
   .rsp_inner_z(rsp_inner_z),
   .rsp_corner_one(rsp_corner_one),
   .rsp_corner_two(rsp_corner_two),
   .rsp_corner_three(rsp_corner_three),
   .rsp_last_of_item(rsp_last_of_item),
   .rsp_index_error(rsp_index_error)
);

>>> dv/tb.sv
module tb
   import fpm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // register index that maps to no register
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 2'd3;

   // one triangle result as the block presents it
   typedef struct packed {
      logic [COORD_W-1:0] ix;
      logic [COORD_W-1:0] iz;
      logic [VCOUNT_W-1:0] c1;
      logic [VCOUNT_W-1:0] c2;
      logic [VCOUNT_W-1:0] c3;
      logic last;
      logic err;
   } tri_type;

   // one row of the directed table; chk marks a typed-in expectation
   typedef struct {
      logic [IDX_W-1:0] j;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] z;
      bit chk;
      tri_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [IDX_W-1:0] req_vertex_index = '0;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic signed [COORD_W-1:0] rsp_inner_x;
   logic signed [COORD_W-1:0] rsp_inner_z;
   logic [VCOUNT_W-1:0] rsp_corner_one;
   logic [VCOUNT_W-1:0] rsp_corner_two;
   logic [VCOUNT_W-1:0] rsp_corner_three;
   logic rsp_last_of_item;
   logic rsp_index_error;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   feathered_polygon_mesh_core dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor's copy of the registers
   logic [VCOUNT_W-1:0] mdl_count = RST_VERTEX_COUNT;
   logic [FRAC_W-1:0] mdl_len = RST_FEATHER_LENGTH;
   logic [FRAC_W-1:0] mdl_cap = RST_FEATHER_SCALE_CAP;

   tri_type pending_tris[$];
   int errors = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int quiet = 0;

   task automatic report(input string what);
      errors++;
      $display("error at %0t: %s", $realtime, what);
   endtask

   // append one expected triangle to the scoreboard queue
   task automatic expect_tri(input tri_type t);
      pending_tris = {pending_tris, t};
   endtask

   function automatic logic [31:0] int_sqrt(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r[31:0];
   endfunction

   // shrink one signed coordinate by scale/65536, rounding half away from zero
   function automatic logic [COORD_W-1:0] shrink(input logic [COORD_W-1:0] raw,
                                                  input logic [16:0] scale);
      logic [COORD_W:0] mag;
      logic [47:0] m;
      mag = raw[COORD_W-1] ? (25'h1000000 - raw) : raw;
      m = (mag * scale + 48'd32768) >> 16;
      return raw[COORD_W-1] ? COORD_W'(25'h1000000 - m) : m[COORD_W-1:0];
   endfunction

   // triangles tied to one vertex under the current register settings
   task automatic predict_triangles(input logic [IDX_W-1:0] j,
                                    input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] z);
      int n;
      int nxt;
      logic [COORD_W:0] mx;
      logic [COORD_W:0] mz;
      logic [31:0] len;
      logic [63:0] frac;
      logic [COORD_W-1:0] ix;
      logic [COORD_W-1:0] iz;
      n = mdl_count;
      if (n < 3) n = 3;
      if (n > DEF_MAX_VERTICES) n = DEF_MAX_VERTICES;
      if (j >= n) begin
         expect_tri('{default: '0, last: 1'b1, err: 1'b1});
         return;
      end
      mx = x[COORD_W-1] ? (25'h1000000 - x) : x;
      mz = z[COORD_W-1] ? (25'h1000000 - z) : z;
      len = int_sqrt(64'(mx) * mx + 64'(mz) * mz);
      if (len == 0) frac = mdl_cap;
      else begin
         frac = (64'(mdl_len) << 16) / len;
         if (frac > mdl_cap) frac = mdl_cap;
      end
      ix = shrink(x, 17'(65536 - frac));
      iz = shrink(z, 17'(65536 - frac));
      nxt = (j + 1) % n;
      // inner fan only for the middle vertices
      if (j >= 1 && j + 2 <= n)
         expect_tri('{ix, iz, 9'(n), 9'(n + j), 9'(n + j + 1), 1'b0, 1'b0});
      expect_tri('{ix, iz, 9'(j), 9'(nxt), 9'(n + j), 1'b0, 1'b0});
      expect_tri('{ix, iz, 9'(n + j), 9'(nxt), 9'(n + nxt), 1'b1, 1'b0});
   endtask

   // random stall on the result side, checking every transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            tri_type got;
            tri_type exp_t;
            quiet <= 0;
            got = '{rsp_inner_x, rsp_inner_z, rsp_corner_one, rsp_corner_two,
                    rsp_corner_three, rsp_last_of_item, rsp_index_error};
            if (pending_tris.size() == 0) report("result transfer with nothing expected");
            else begin
               exp_t = pending_tris.pop_front();
               if (got.ix !== exp_t.ix) report($sformatf("inner_x %h want %h", got.ix, exp_t.ix));
               if (got.iz !== exp_t.iz) report($sformatf("inner_z %h want %h", got.iz, exp_t.iz));
               if (got.c1 !== exp_t.c1)
                  report($sformatf("corner_one %0d want %0d", got.c1, exp_t.c1));
               if (got.c2 !== exp_t.c2)
                  report($sformatf("corner_two %0d want %0d", got.c2, exp_t.c2));
               if (got.c3 !== exp_t.c3)
                  report($sformatf("corner_three %0d want %0d", got.c3, exp_t.c3));
               if (got.last !== exp_t.last) report("last_of_item mismatch");
               if (got.err !== exp_t.err) report("index_error mismatch");
            end
         end else if (!(req_valid && !req_stall) && !(csr_valid && csr_ready)) begin
            quiet <= quiet + 1;
         end else begin
            quiet <= 0;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // watchdog on consecutive cycles without any transfer
   always @(posedge clock) begin
      if (quiet > 20000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // one input transfer, with random sender gaps before it; valid stays up
   // after the transfer so the next vertex can follow without a gap
   task automatic send_vertex(input logic [IDX_W-1:0] j, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] z);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_index <= j;
      req_pos_x <= x;
      req_pos_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_triangles(j, x, z);
   endtask

   // drain and settle before touching the registers
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_tris.size() != 0) @(posedge clock);
      repeat (TOTAL_ST + 10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_VERTEX_COUNT: mdl_count = val[VCOUNT_W-1:0];
         CSR_FEATHER_LENGTH: mdl_len = val;
         CSR_FEATHER_SCALE_CAP: mdl_cap = val;
         default: ;
      endcase
   endtask

   task automatic set_regs(input int n, input int l, input int s);
      drain();
      write_reg(CSR_VERTEX_COUNT, 16'(n));
      write_reg(CSR_FEATHER_LENGTH, 16'(l));
      write_reg(CSR_FEATHER_SCALE_CAP, 16'(s));
   endtask

   // random vertex: mostly legal indices, small and mid coordinates, some extremes
   task automatic random_vertex(input int n);
      logic [IDX_W-1:0] j;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] z;
      j = ($urandom_range(9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(n - 1));
      case ($urandom_range(3))
         0: begin
            x = COORD_W'($urandom);
            z = COORD_W'($urandom);
         end
         1: begin
            x = COORD_W'($signed($urandom_range(131072)) - 65536);
            z = COORD_W'($signed($urandom_range(131072)) - 65536);
         end
         2: begin
            x = $urandom_range(1) ? 24'h800000 : 24'h7fffff;
            z = COORD_W'($urandom_range(3)) - 24'd1;
         end
         default: begin
            x = COORD_W'($signed($urandom_range(32)) - 16);
            z = COORD_W'($signed($urandom_range(32)) - 16);
         end
      endcase
      send_vertex(j, x, z);
   endtask

   row_type plan[$];

   initial begin
      int n_used;
      tri_type zero_err;
      zero_err = '{default: '0, last: 1'b1, err: 1'b1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // directed table under reset settings, N = 4
      plan = '{
         '{8'd4, 24'h010000, 24'h0, 1'b1, zero_err},   // index equal to N
         '{8'd255, 24'h7fffff, 24'h800000, 1'b1, zero_err},
         '{8'd0, 24'h0, 24'h0, 1'b0, '0},              // zero-length vertex
         '{8'd0, 24'h010000, 24'h0, 1'b0, '0},
         '{8'd1, 24'h0, 24'h010000, 1'b0, '0},
         '{8'd2, 24'hff0000, 24'h0, 1'b0, '0},
         '{8'd3, 24'h0, 24'hff0000, 1'b0, '0},
         '{8'd1, 24'h7fffff, 24'h7fffff, 1'b0, '0},
         '{8'd2, 24'h800000, 24'h800000, 1'b0, '0},
         '{8'd3, 24'h000001, 24'hffffff, 1'b0, '0},
         '{8'd0, 24'h555555, 24'haaaaaa, 1'b0, '0},
         '{8'd1, 24'haaaaaa, 24'h555555, 1'b0, '0}
      };
      foreach (plan[i]) begin
         if (plan[i].chk) begin
            drain();
            send_vertex(plan[i].j, plan[i].x, plan[i].z);
            if (pending_tris[$] !== plan[i].want) report("table row disagrees with predictor");
         end else begin
            send_vertex(plan[i].j, plan[i].x, plan[i].z);
         end
      end
      // count below three clamps to three, large count clamps to the maximum
      set_regs(0, 0, 0);
      for (int j = 0; j < 4; j++) send_vertex(IDX_W'(j), 24'h020000, 24'hfe0000);
      set_regs(511, 65535, 65535);
      send_vertex(8'd255, 24'h7fffff, 24'h0);
      send_vertex(8'd254, 24'h000100, 24'h000100);
      send_vertex(8'd0, 24'h0, 24'h0);
      // random phases over several settings and idling modes
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 21 : (ph == 1) ? 75 : 0;
         recv_idle = (ph == 0) ? 75 : (ph == 1) ? 21 : 0;
         for (int k = 0; k < 4; k++) begin
            case (k)
               0: set_regs(3, $urandom_range(65535), $urandom_range(65535));
               1: set_regs(256, 65535, 65535);
               2: set_regs($urandom_range(3, 40), $urandom_range(65535), $urandom_range(65535));
               default: set_regs($urandom_range(511), $urandom_range(65535), $urandom_range(65535));
            endcase
            n_used = mdl_count < 3 ? 3 : (mdl_count > 256 ? 256 : mdl_count);
            repeat (33) random_vertex(n_used);
         end
      end
      // unknown register index must be ignored
      drain();
      write_reg(CSR_NO_REG, 16'hffff);
      send_vertex(8'd1, 24'h030000, 24'h040000);
      drain();
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

>>> feathered_polygon_mesh_core.f
src/fpm_pkg.sv
src/feathered_polygon_mesh_core.sv
src/fpm_checker.sv
dv/tb.sv
